/* src/sadbm_pkg.sv */
// Shared types and constants for the SAD block-matching search.
package sadbm_pkg;

	// block and window geometry
	localparam int BLOCK_SIZE = 16;
	localparam int H_SPAN     = 64;
	localparam int V_SPAN     = 340;

	localparam int DX_ORIGIN = -32;
	localparam int DY_ORIGIN = -40;

	localparam logic [1:0] REG_MIN_DX = 2'd0;
	localparam logic [1:0] REG_MAX_DX = 2'd1;
	localparam logic [1:0] REG_MIN_DY = 2'd2;
	localparam logic [1:0] REG_MAX_DY = 2'd3;

	// one loaded item as it travels from the front end to the search engine
	typedef struct packed {
		logic       action;
		logic [7:0] pixel;
		logic       last;
	} sadbm_item_t;

	// search result
	typedef struct packed {
		logic signed [6:0] best_dx;
		logic signed [9:0] best_dy;
		logic [15:0]       best_sad;
		logic              empty_range;
	} sadbm_result_t;

endpackage

/* src/sadbm_front.sv */
// Front end: accepts input transfers and buffers them in a short queue.
module sadbm_front
	import sadbm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  sadbm_item_t in_item,
	output logic        q_valid,
	input  logic        q_take,
	output sadbm_item_t q_item
);

	sadbm_item_t fifo_q [4];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;
	logic        push;

	assign in_stall = (cnt_q == 3'd4);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 3'd0);
	assign q_item   = fifo_q[rd_q];

	// payload storage
	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= in_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (q_take) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, q_take};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("queue read while empty");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_take) |=> cnt_q == $past(cnt_q) + 3'd1)
		else $error("fill count mismatch");

endmodule

/* src/sadbm_engine.sv */
// Back end: stores pixels and runs the full SAD search on the last pixel.
module sadbm_engine
	import sadbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_take,
	input  sadbm_item_t       q_item,
	input  logic signed [6:0] min_dx,
	input  logic signed [6:0] max_dx,
	input  logic signed [9:0] min_dy,
	input  logic signed [9:0] max_dy,
	output logic              out_valid,
	input  logic              out_stall,
	output sadbm_result_t     out_res
);

	localparam int WIN_W     = BLOCK_SIZE + H_SPAN;
	localparam int WIN_H     = BLOCK_SIZE + V_SPAN;
	localparam int REF_DEPTH = BLOCK_SIZE * BLOCK_SIZE;
	localparam int WIN_DEPTH = WIN_W * WIN_H;
	localparam int RA = $clog2(REF_DEPTH);
	localparam int WA = $clog2(WIN_DEPTH);
	localparam int BA = $clog2(BLOCK_SIZE);
	localparam int CW = $clog2(WIN_W + 1);
	localparam int RW = $clog2(WIN_H + 1);
	localparam int HI_X = DX_ORIGIN + H_SPAN;
	localparam int HI_Y = DY_ORIGIN + V_SPAN;

	typedef enum logic [2:0] {S_LOAD, S_SETUP, S_RUN, S_DRAIN, S_OUT} state_t;

	logic [7:0] ref_mem [REF_DEPTH];
	logic [7:0] win_mem [WIN_DEPTH];

	state_t            state_q;
	logic [14:0]       pos_q;
	logic              act_q;
	logic signed [10:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q, dx_q, dy_q;
	logic [BA-1:0]     x_q, y_q;
	logic [16:0]       acc_q;
	logic [15:0]       best_q;
	logic              found_q;
	logic signed [6:0] bdx_q;
	logic signed [9:0] bdy_q;
	logic [WA-1:0]     waddr_s1;
	logic [RA-1:0]     raddr_s1;
	logic              v_s1, v_s2, end_s1, end_s2;
	logic [7:0]        a_s2, b_s2;
	logic signed [6:0] pdx_s1, pdx_s2;
	logic signed [9:0] pdy_s1, pdy_s2;
	logic              busy;
	logic [14:0]       pos_eff;
	logic [CW-1:0]     col;
	logic [RW-1:0]     row;
	logic [8:0]        diff;
	logic [16:0]       sum_n;
	logic signed [10:0] cl_lx, cl_hx, cl_ly, cl_hy;

	assign q_take  = q_valid && (state_q == S_LOAD);
	assign pos_eff = (q_item.action != act_q) ? 15'd0 : pos_q;

	// clamped ranges
	always_comb begin
		cl_lx = (11'(min_dx) < 11'(DX_ORIGIN)) ? 11'(DX_ORIGIN) : 11'(min_dx);
		cl_hx = (11'(max_dx) > 11'(HI_X)) ? 11'(HI_X) : 11'(max_dx);
		cl_ly = (11'(min_dy) < 11'(DY_ORIGIN)) ? 11'(DY_ORIGIN) : 11'(min_dy);
		cl_hy = (11'(max_dy) > 11'(HI_Y)) ? 11'(HI_Y) : 11'(max_dy);
	end

	// window coordinates of the current pixel
	assign col = CW'(dx_q - 11'(DX_ORIGIN)) + CW'(x_q);
	assign row = RW'(dy_q - 11'(DY_ORIGIN)) + RW'(y_q);

	// stores: pixel writes and pipelined reads
	always_ff @(posedge clk) begin
		if (q_take && !q_item.action && pos_eff < 15'(REF_DEPTH))
			ref_mem[pos_eff[RA-1:0]] <= q_item.pixel;
		if (q_take && q_item.action && pos_eff < 15'(WIN_DEPTH))
			win_mem[pos_eff[WA-1:0]] <= q_item.pixel;
		a_s2 <= ref_mem[raddr_s1];
		b_s2 <= win_mem[waddr_s1];
		waddr_s1 <= WA'(32'(row) * WIN_W + 32'(col));
		raddr_s1 <= RA'({y_q, x_q});
		pdx_s1 <= 7'(dx_q);
		pdy_s1 <= 10'(dy_q);
		pdx_s2 <= pdx_s1;
		pdy_s2 <= pdy_s1;
	end

	assign diff  = (a_s2 > b_s2) ? {1'b0, a_s2 - b_s2} : {1'b0, b_s2 - a_s2};
	assign sum_n = acc_q + {8'd0, diff};
	assign busy  = (state_q == S_RUN);

	// sequencer: one pixel difference per cycle, compare at block end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pos_q   <= '0;
			act_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			end_s1  <= 1'b0;
			end_s2  <= 1'b0;
			acc_q   <= '0;
			found_q <= 1'b0;
			best_q  <= '0;
			bdx_q   <= '0;
			bdy_q   <= '0;
			lo_x_q  <= '0;
			hi_x_q  <= '0;
			lo_y_q  <= '0;
			hi_y_q  <= '0;
			dx_q    <= '0;
			dy_q    <= '0;
			x_q     <= '0;
			y_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			v_s1   <= busy;
			end_s1 <= busy && (x_q == BA'(BLOCK_SIZE - 1)) && (y_q == BA'(BLOCK_SIZE - 1));
			v_s2   <= v_s1;
			end_s2 <= end_s1;
			if (v_s2) begin
				if (end_s2) begin
					acc_q <= '0;
					if (!found_q || sum_n < {1'b0, best_q}) begin
						found_q <= 1'b1;
						best_q  <= (sum_n > 17'hFFFF) ? 16'hFFFF : sum_n[15:0];
						bdx_q   <= pdx_s2;
						bdy_q   <= pdy_s2;
					end
				end else begin
					acc_q <= sum_n;
				end
			end
			unique case (state_q)
				S_LOAD: begin
					if (q_take) begin
						act_q <= q_item.action;
						pos_q <= (pos_eff < 15'h7FFF) ? pos_eff + 15'd1 : pos_eff;
						if (q_item.last) begin
							pos_q   <= '0;
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					lo_x_q  <= cl_lx;
					hi_x_q  <= cl_hx;
					dx_q    <= cl_lx;
					dy_q    <= cl_ly;
					hi_y_q  <= cl_hy;
					lo_y_q  <= cl_ly;
					x_q     <= '0;
					y_q     <= '0;
					acc_q   <= '0;
					found_q <= 1'b0;
					best_q  <= '0;
					bdx_q   <= '0;
					bdy_q   <= '0;
					state_q <= (cl_lx <= cl_hx && cl_ly <= cl_hy) ? S_RUN : S_DRAIN;
				end
				S_RUN: begin
					x_q <= x_q + BA'(1);
					if (x_q == BA'(BLOCK_SIZE - 1)) begin
						x_q <= '0;
						y_q <= y_q + BA'(1);
						if (y_q == BA'(BLOCK_SIZE - 1)) begin
							y_q <= '0;
							if (dx_q == hi_x_q) begin
								dx_q <= lo_x_q;
								if (dy_q == hi_y_q) state_q <= S_DRAIN;
								else dy_q <= dy_q + 11'sd1;
							end else begin
								dx_q <= dx_q + 11'sd1;
							end
						end
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						out_valid <= 1'b1;
						state_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= S_LOAD;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	assign out_res.best_dx     = found_q ? bdx_q : 7'sd0;
	assign out_res.best_dy     = found_q ? bdy_q : 10'sd0;
	assign out_res.best_sad    = found_q ? best_q : 16'd0;
	assign out_res.empty_range = !found_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> !q_take) else $error("item taken during search");
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT) else $error("result outside output state");

endmodule

/* src/sad_block_match_search.sv */
// Top level of the SAD full-search block matcher: config registers, input queue, engine.
// Throughput: one load transfer per cycle into a 4-entry queue; a search holds the engine
// (one pixel difference per cycle), input stalls once full.
// After the transfer carrying last, the engine runs setup, the search (skipped for an empty
// range), a drain of its read pipeline and the output state, where out_valid is raised.
// Reset (arst_n low): registers to full range, load position to zero, stores undefined.
module sad_block_match_search
	import sadbm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [7:0]        pixel,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic signed [6:0] best_dx,
	output logic signed [9:0] best_dy,
	output logic [15:0]       best_sad,
	output logic              empty_range,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic signed [6:0] min_dx_q, max_dx_q;
	logic signed [9:0] min_dy_q, max_dy_q;
	logic          q_valid, q_take;
	sadbm_item_t   q_item, in_item;
	sadbm_result_t res;

	assign pready  = 1'b1;
	assign in_item = '{action: action, pixel: pixel, last: last};

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dx_q <= -7'sd32;
			max_dx_q <= 7'sd32;
			min_dy_q <= -10'sd40;
			max_dy_q <= 10'sd300;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			case (paddr[3:2])
				REG_MIN_DX: min_dx_q <= pwdata[6:0];
				REG_MAX_DX: max_dx_q <= pwdata[6:0];
				REG_MIN_DY: min_dy_q <= pwdata[9:0];
				REG_MAX_DY: max_dy_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[3:2])
			REG_MIN_DX: prdata = 32'(min_dx_q);
			REG_MAX_DX: prdata = 32'(max_dx_q);
			REG_MIN_DY: prdata = 32'(min_dy_q);
			default:    prdata = 32'(max_dy_q);
		endcase
	end

	sadbm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	sadbm_engine u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
		.min_dx(min_dx_q), .max_dx(max_dx_q), .min_dy(min_dy_q), .max_dy(max_dy_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_res(res)
	);

	assign best_dx     = res.best_dx;
	assign best_dy     = res.best_dy;
	assign best_sad    = res.best_sad;
	assign empty_range = res.empty_range;

endmodule

/* sim/tb_sad_block_match_search.sv */
// Self-checking testbench for the SAD full-search block matcher.
module tb_sad_block_match_search
	import sadbm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLK       = BLOCK_SIZE;
	localparam int WIN_W     = BLK + H_SPAN;
	localparam int WIN_H     = BLK + V_SPAN;
	localparam int WIN_DEPTH = WIN_W * WIN_H;
	localparam int REF_DEPTH = BLK * BLK;
	localparam int POS_SAT   = 32767;
	localparam int IDLE_LIMIT = 60000;
	localparam int HOLD_CYCLES = 1500;
	// window prefix that covers the top-left corner for five horizontal offsets
	localparam int WIN_PREFIX = 15 * WIN_W + BLK + 4;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = 1'b0;
	logic [7:0]        pixel = '0;
	logic              last = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic signed [6:0] best_dx;
	logic signed [9:0] best_dy;
	logic [15:0]       best_sad;
	logic              empty_range;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [3:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	sad_block_match_search u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [7:0]    block_px [REF_DEPTH];
	logic [7:0]    window_px [WIN_DEPTH];
	int            load_pos;
	logic          load_act;
	int            lo_dx_reg, hi_dx_reg, lo_dy_reg, hi_dy_reg;
	sadbm_result_t pending_results [$];

	// stimulus controls
	bit sender_gaps;
	bit receiver_gaps;
	bit hold_request;
	int mismatch_count;
	int idle_cycles;

	// best displacement over the clamped range, first strict minimum wins
	function automatic sadbm_result_t search_best();
		sadbm_result_t r;
		int lx, hx, ly, hy, sum, best;
		bit found;
		lx = (lo_dx_reg < DX_ORIGIN) ? DX_ORIGIN : lo_dx_reg;
		hx = (hi_dx_reg > DX_ORIGIN + H_SPAN) ? DX_ORIGIN + H_SPAN : hi_dx_reg;
		ly = (lo_dy_reg < DY_ORIGIN) ? DY_ORIGIN : lo_dy_reg;
		hy = (hi_dy_reg > DY_ORIGIN + V_SPAN) ? DY_ORIGIN + V_SPAN : hi_dy_reg;
		r = '0;
		best = 0;
		found = 1'b0;
		if (lx <= hx && ly <= hy) begin
			for (int dy = ly; dy <= hy; dy++) begin
				for (int dx = lx; dx <= hx; dx++) begin
					sum = 0;
					for (int y = 0; y < BLK; y++) begin
						for (int x = 0; x < BLK; x++) begin
							int a, b;
							a = block_px[y*BLK + x];
							b = window_px[(dy - DY_ORIGIN + y)*WIN_W + dx - DX_ORIGIN + x];
							sum += (a > b) ? a - b : b - a;
						end
					end
					if (!found || sum < best) begin
						found = 1'b1;
						best = sum;
						r.best_dx = dx[6:0];
						r.best_dy = dy[9:0];
					end
				end
			end
		end
		r.best_sad = (best > 65535) ? 16'hFFFF : best[15:0];
		r.empty_range = !found;
		return r;
	endfunction

	// update the predicted stores for one accepted transfer
	task automatic predict_item(input logic act, input logic [7:0] px, input logic lst);
		if (act != load_act) begin
			load_pos = 0;
			load_act = act;
		end
		if (!act && load_pos < REF_DEPTH) block_px[load_pos] = px;
		if (act && load_pos < WIN_DEPTH) window_px[load_pos] = px;
		if (load_pos < POS_SAT) load_pos++;
		if (lst) begin
			load_pos = 0;
			pending_results.insert(pending_results.size(), search_best());
		end
	endtask

	// drive one item and wait for its transfer
	task automatic send_item(input logic act, input logic [7:0] px, input logic lst);
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		pixel = px;
		last = lst;
		do @(posedge clk); while (in_stall);
		predict_item(act, px, lst);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// register write: setup then access phase
	task automatic reg_write(input logic [1:0] idx, input int value);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_MIN_DX: lo_dx_reg = $signed(value[6:0]);
			REG_MAX_DX: hi_dx_reg = $signed(value[6:0]);
			REG_MIN_DY: lo_dy_reg = $signed(value[9:0]);
			default:    hi_dy_reg = $signed(value[9:0]);
		endcase
	endtask

	task automatic set_range(input int mdx, input int xdx, input int mdy, input int xdy);
		wait_idle();
		reg_write(REG_MIN_DX, mdx);
		reg_write(REG_MAX_DX, xdx);
		reg_write(REG_MIN_DY, mdy);
		reg_write(REG_MAX_DY, xdy);
	endtask

	task automatic load_block(input int count, input int fixed);
		for (int i = 0; i < count; i++)
			send_item(1'b0, (fixed < 0) ? 8'($urandom) : 8'(fixed), 1'b0);
	endtask

	// window prefix; the final pixel carries last
	task automatic load_window(input int count, input int fixed);
		for (int i = 0; i < count; i++)
			send_item(1'b1, (fixed < 0) ? 8'($urandom) : 8'(fixed), i == count - 1);
	endtask

	// first full load: register extremes clamp to the corner, every sum is the
	// largest possible, so all displacements tie; then a bright top strip
	task automatic test_ties_and_extremes();
		set_range(-64, DX_ORIGIN + 4, -512, DY_ORIGIN);
		load_block(REF_DEPTH, 255);
		load_window(WIN_PREFIX, 0);
		set_range(DX_ORIGIN + 2, DX_ORIGIN + 4, DY_ORIGIN, DY_ORIGIN);
		load_window(BLK + 4, 255);
	endtask

	// empty ranges on each axis, with register extremes
	task automatic test_empty_ranges();
		set_range(63, -64, -40, -40);
		load_window(3, -1);
		set_range(-64, -33, 0, 0);
		load_window(2, -1);
		set_range(0, 0, 511, -512);
		load_window(1, -1);
		set_range(5, 5, 301, 511);
		load_window(4, -1);
	endtask

	// receiver holds off while searches keep arriving
	task automatic test_backpressure();
		set_range(DX_ORIGIN + 2, DX_ORIGIN + 3, DY_ORIGIN, DY_ORIGIN);
		hold_request = 1'b1;
		for (int n = 0; n < 6; n++) begin
			load_block($urandom_range(1, 4), -1);
			load_window($urandom_range(1, 4), -1);
		end
	endtask

	// random short sequences, with noise and range changes inside the loaded corner
	task automatic test_random(input int seqs);
		int lo, hi, n;
		for (int s = 0; s < seqs; s++) begin
			if ($urandom_range(0, 3) == 0) begin
				lo = $urandom_range(0, 4);
				hi = lo + $urandom_range(0, 4 - lo);
				if ($urandom_range(0, 9) == 0)
					set_range(DX_ORIGIN + lo, DX_ORIGIN + lo - 1, DY_ORIGIN, DY_ORIGIN);
				else
					set_range(DX_ORIGIN + lo, DX_ORIGIN + hi,
						DY_ORIGIN - int'($urandom_range(0, 30)), DY_ORIGIN);
			end
			if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					send_item(1'b1, 8'($urandom), 1'b0);
			end
			load_block($urandom_range(0, 4), -1);
			load_window($urandom_range(1, 4), -1);
		end
	endtask

	// result checking and watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result dx=%0d dy=%0d sad=%0d empty=%0b",
						best_dx, best_dy, best_sad, empty_range);
			end else begin
				sadbm_result_t exp_r;
				exp_r = pending_results.pop_front();
				if (best_dx !== exp_r.best_dx || best_dy !== exp_r.best_dy ||
				    best_sad !== exp_r.best_sad || empty_range !== exp_r.empty_range) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"result mismatch: exp dx=%0d dy=%0d sad=%0d empty=%0b,",
							" got dx=%0d dy=%0d sad=%0d empty=%0b"},
							exp_r.best_dx, exp_r.best_dy, exp_r.best_sad,
							exp_r.empty_range, best_dx, best_dy, best_sad, empty_range);
				end
			end
		end
	end

	// receiver stall: random bursts, or one long hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			out_stall = 1'b1;
			repeat (HOLD_CYCLES - 1) @(negedge clk);
			hold_request = 1'b0;
			out_stall = 1'b0;
		end else if (receiver_gaps && $urandom_range(0, 5) == 0) begin
			out_stall = 1'b1;
			repeat ($urandom_range(1, 3) - 1) @(negedge clk);
		end else begin
			out_stall = 1'b0;
		end
	end

	initial begin
		mismatch_count = 0;
		idle_cycles = 0;
		hold_request = 1'b0;
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		load_pos = 0;
		load_act = 1'b0;
		lo_dx_reg = -32;
		hi_dx_reg = 32;
		lo_dy_reg = -40;
		hi_dy_reg = 300;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_ties_and_extremes();
		test_empty_ranges();
		test_backpressure();
		test_random(16);
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		test_random(8);

		wait_idle();
		repeat (50) @(negedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
